/* hw/rtl/cidr_access_filter_core_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the CIDR access filter
// Immediate-implication and next-cycle-implication checks on clk and rst.
// ----------------------------------------------------------------------------
`ifndef CIDR_ACCESS_FILTER_CORE_ASSERT_SVH
`define CIDR_ACCESS_FILTER_CORE_ASSERT_SVH

`ifndef SYNTHESIS

`define CAF_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`define CAF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define CAF_ASSERT_IMPL(label, ante, cons, msg)

`define CAF_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

/* hw/rtl/caf_pkg.sv */
// ----------------------------------------------------------------------------
// CIDR access filter package
// Shared types and constants of the prefix-rule access filter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package caf_pkg;

  localparam int CFG_INDEX_W = 2;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_FILTER_ENABLE = 2'd0,
    CFG_USER_RULES    = 2'd1
  } cfg_index_t;

  typedef enum logic [1:0] {
    KIND_CHECK     = 2'd0,
    KIND_ADD_ALLOW = 2'd1,
    KIND_ADD_DENY  = 2'd2,
    KIND_CLEAR     = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_FULL     = 2'd1,
    STATUS_TOO_LONG = 2'd2
  } outcome_t;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_ALLOW  = 2'd1,
    ST_DENY   = 2'd2,
    ST_RESULT = 2'd3
  } state_t;

  localparam logic [7:0] V4_MAX_PREFIX = 8'd32;
  localparam logic [7:0] V6_MAX_PREFIX = 8'd128;
  localparam logic [7:0] V4_LOOPBACK_NET = 8'd127;

  typedef struct packed {
    logic [63:0] high;
    logic [63:0] low;
    logic        family;
  } addr_t;

  typedef struct packed {
    logic [63:0] high;
    logic [63:0] low;
    logic [7:0]  prefix;
    logic        family;
  } rule_t;

endpackage

`default_nettype wire

/* hw/rtl/caf_ram.sv */
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module caf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/caf_rule_cmp.sv */
// ----------------------------------------------------------------------------
// CIDR rule comparator
// Tests whether an address lies inside one prefix rule of the same family.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module caf_rule_cmp (
  input  wire caf_pkg::rule_t rule,
  input  wire caf_pkg::addr_t addr,
  output logic                hit
);

  import caf_pkg::*;

  logic [31:0]  v4_mask;
  logic [127:0] v6_mask;
  logic         v4_agree;
  logic         v6_agree;

  // Shifts of the ones word by its width or more leave nothing, so long
  // prefixes behave as full-length masks.
  assign v4_mask = ~({32{1'b1}} >> rule.prefix);
  assign v6_mask = ~({128{1'b1}} >> rule.prefix);

  assign v4_agree = ((rule.low[31:0] ^ addr.low[31:0]) & v4_mask) == 32'd0;
  assign v6_agree = (({rule.high, rule.low} ^ {addr.high, addr.low}) & v6_mask) == 128'd0;

  assign hit = (rule.family == addr.family) && (addr.family ? v6_agree : v4_agree);

endmodule

`default_nettype wire

/* hw/rtl/cidr_access_filter_core.sv */
// ----------------------------------------------------------------------------
// CIDR access filter core
// Allow and deny tables of IPv4 and IPv6 prefix rules held in RAM, with an
// address check that walks the tables one entry per cycle.
// ----------------------------------------------------------------------------
//  Channel   Signals                                       Handshake
//  req       kind, address_high, address_low, is_ipv6,     req_valid / req_stall
//            prefix_length
//  rsp       allowed, status                               rsp_valid / rsp_stall
//  cfg       cfg_index, cfg_data                           cfg_valid / cfg_ready
//
// An add or clear goes from idle straight to the result state; a check walks the
// allow table, then the deny table where needed, reading each table RAM in turn.
// One item is worked on at a time; a new transfer is taken once the previous
// result has moved into the output register, which holds it under rsp_stall.
// Reset empties both tables; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

`include "cidr_access_filter_core_assert.svh"

module cidr_access_filter_core #(
  parameter int ALLOW_DEPTH = 16,
  parameter int DENY_DEPTH  = 16
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             req_valid,
  output logic                                  req_stall,
  input  wire logic [1:0]                       kind,
  input  wire logic [63:0]                      address_high,
  input  wire logic [63:0]                      address_low,
  input  wire logic                             is_ipv6,
  input  wire logic [7:0]                       prefix_length,
  output logic                                  rsp_valid,
  input  wire logic                             rsp_stall,
  output logic                                  allowed,
  output logic [1:0]                            status,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [caf_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic                             cfg_data
);

  import caf_pkg::*;

  localparam int ACW = $clog2(ALLOW_DEPTH + 1);
  localparam int DCW = $clog2(DENY_DEPTH + 1);
  localparam int AAW = (ALLOW_DEPTH > 1) ? $clog2(ALLOW_DEPTH) : 1;
  localparam int DAW = (DENY_DEPTH > 1) ? $clog2(DENY_DEPTH) : 1;
  localparam int IW  = (ACW > DCW) ? ACW : DCW;
  localparam int RW  = $bits(rule_t);

  state_t         state, state_next;
  logic [IW-1:0]  idx, idx_next;
  logic           pend, pend_next;
  logic [ACW-1:0] allow_count, allow_count_next;
  logic [DCW-1:0] deny_count, deny_count_next;
  logic           filter_enable;
  logic           user_rules_present;
  addr_t          addr;
  logic           load_addr;
  logic           res_allowed, res_allowed_next;
  outcome_t       res_status, res_status_next;
  logic           rsp_load;

  addr_t          in_addr;
  rule_t          in_rule;
  logic           prefix_bad;
  logic           in_loopback;
  logic           accept;
  logic           rsp_take;

  logic           allow_wr, allow_rd, deny_wr, deny_rd;
  rule_t          allow_rule, deny_rule, cmp_rule;
  logic           hit;

  assign accept    = req_valid && !req_stall;
  assign req_stall = (state != ST_IDLE);
  assign rsp_take  = rsp_valid && !rsp_stall;
  assign cfg_ready = 1'b1;

  assign in_addr.high   = is_ipv6 ? address_high : 64'd0;
  assign in_addr.low    = is_ipv6 ? address_low : {32'd0, address_low[31:0]};
  assign in_addr.family = is_ipv6;

  assign in_rule.high   = in_addr.high;
  assign in_rule.low    = in_addr.low;
  assign in_rule.prefix = prefix_length;
  assign in_rule.family = is_ipv6;

  assign prefix_bad  = prefix_length > (is_ipv6 ? V6_MAX_PREFIX : V4_MAX_PREFIX);
  assign in_loopback = is_ipv6 ? (address_high == 64'd0 && address_low == 64'd1)
                               : (address_low[31:24] == V4_LOOPBACK_NET);

  caf_ram #(
    .WIDTH(RW),
    .DEPTH(ALLOW_DEPTH)
  ) u_allow_ram (
    .clk     (clk),
    .wr_en   (allow_wr),
    .wr_addr (allow_count[AAW-1:0]),
    .wr_data (in_rule),
    .rd_en   (allow_rd),
    .rd_addr (idx[AAW-1:0]),
    .rd_data (allow_rule)
  );

  caf_ram #(
    .WIDTH(RW),
    .DEPTH(DENY_DEPTH)
  ) u_deny_ram (
    .clk     (clk),
    .wr_en   (deny_wr),
    .wr_addr (deny_count[DAW-1:0]),
    .wr_data (in_rule),
    .rd_en   (deny_rd),
    .rd_addr (idx[DAW-1:0]),
    .rd_data (deny_rule)
  );

  assign cmp_rule = (state == ST_DENY) ? deny_rule : allow_rule;

  caf_rule_cmp u_cmp (
    .rule (cmp_rule),
    .addr (addr),
    .hit  (hit)
  );

  always_comb begin
    state_next       = state;
    idx_next         = idx;
    pend_next        = 1'b0;
    allow_count_next = allow_count;
    deny_count_next  = deny_count;
    res_allowed_next = res_allowed;
    res_status_next  = res_status;
    load_addr        = 1'b0;
    allow_wr         = 1'b0;
    deny_wr          = 1'b0;
    allow_rd         = 1'b0;
    deny_rd          = 1'b0;
    rsp_load         = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          res_allowed_next = 1'b0;
          res_status_next  = STATUS_OK;
          idx_next         = '0;
          state_next       = ST_RESULT;
          unique case (kind_t'(kind))
            KIND_CHECK: begin
              load_addr        = 1'b1;
              res_allowed_next = 1'b1;
              if (filter_enable && !in_loopback) begin
                if (allow_count != '0) begin
                  state_next = ST_ALLOW;
                end else if (deny_count != '0) begin
                  state_next = ST_DENY;
                end
              end
            end
            KIND_CLEAR: begin
              allow_count_next = '0;
              deny_count_next  = '0;
            end
            KIND_ADD_ALLOW: begin
              if (prefix_bad) begin
                res_status_next = STATUS_TOO_LONG;
              end else if (allow_count == ACW'(ALLOW_DEPTH)) begin
                res_status_next = STATUS_FULL;
              end else begin
                allow_wr         = 1'b1;
                allow_count_next = allow_count + 1'b1;
              end
            end
            KIND_ADD_DENY: begin
              if (prefix_bad) begin
                res_status_next = STATUS_TOO_LONG;
              end else if (deny_count == DCW'(DENY_DEPTH)) begin
                res_status_next = STATUS_FULL;
              end else begin
                deny_wr         = 1'b1;
                deny_count_next = deny_count + 1'b1;
              end
            end
            default: begin
              state_next = ST_RESULT;
            end
          endcase
        end
      end
      ST_ALLOW: begin
        if (pend && hit) begin
          idx_next   = '0;
          state_next = (deny_count != '0) ? ST_DENY : ST_RESULT;
        end else if (idx < IW'(allow_count)) begin
          allow_rd  = 1'b1;
          idx_next  = idx + 1'b1;
          pend_next = 1'b1;
        end else if (!pend) begin
          idx_next = '0;
          if (user_rules_present) begin
            state_next = (deny_count != '0) ? ST_DENY : ST_RESULT;
          end else begin
            res_allowed_next = 1'b0;
            state_next       = ST_RESULT;
          end
        end
      end
      ST_DENY: begin
        if (pend && hit) begin
          res_allowed_next = 1'b0;
          state_next       = ST_RESULT;
        end else if (idx < IW'(deny_count)) begin
          deny_rd   = 1'b1;
          idx_next  = idx + 1'b1;
          pend_next = 1'b1;
        end else if (!pend) begin
          state_next = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (!rsp_valid || rsp_take) begin
          rsp_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= ST_IDLE;
      idx                <= '0;
      pend               <= 1'b0;
      allow_count        <= '0;
      deny_count         <= '0;
      filter_enable      <= 1'b0;
      user_rules_present <= 1'b0;
      rsp_valid          <= 1'b0;
    end else begin
      state       <= state_next;
      idx         <= idx_next;
      pend        <= pend_next;
      allow_count <= allow_count_next;
      deny_count  <= deny_count_next;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_FILTER_ENABLE) begin
          filter_enable <= cfg_data;
        end
        if (cfg_index == CFG_USER_RULES) begin
          user_rules_present <= cfg_data;
        end
      end
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_take) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    res_allowed <= res_allowed_next;
    res_status  <= res_status_next;
    if (load_addr) begin
      addr <= in_addr;
    end
    if (rsp_load) begin
      allowed <= res_allowed;
      status  <= res_status;
    end
  end

  `CAF_ASSERT_NEXT(a_accept_leaves_idle, accept, state != ST_IDLE, "item taken but idle")
  `CAF_ASSERT_IMPL(a_allow_read_in_range, allow_rd, idx < IW'(allow_count), "allow read past fill")
  `CAF_ASSERT_IMPL(a_deny_read_in_range, deny_rd, idx < IW'(deny_count), "deny read past fill")
  `CAF_ASSERT_IMPL(a_rsp_from_result, $rose(rsp_valid), $past(state == ST_RESULT), "stray result")

endmodule

`default_nettype wire

/* test/cidr_access_filter_core_tb.sv */
// ----------------------------------------------------------------------------
// CIDR access filter core testbench
// Drives check, add and clear requests through the request channel and
// predicts the verdict and status of each transfer from a private copy of the
// allow and deny tables. Configuration changes only while the core is idle.
// The sender idles and the receiver stalls in random bursts, and the receiver holds
// off once for a long stretch.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cidr_access_filter_core_tb;

  import caf_pkg::*;

  localparam int ALLOW_DEPTH = 16;
  localparam int DENY_DEPTH = 16;
  localparam int CYCLE_LIMIT = 600000;
  localparam int PHASES = 10;
  localparam int PHASE_ITEMS = 108;
  localparam int HOLD_AFTER = 200;
  localparam int HOLD_CYCLES = 400;
  localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 2'd2;

  typedef struct packed {
    kind_t       kind;
    logic [63:0] high;
    logic [63:0] low;
    logic        v6;
    logic [7:0]  plen;
  } filter_req_t;

  typedef struct packed {
    logic     allowed;
    outcome_t status;
  } verdict_t;

  logic clk;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  logic [1:0] kind = KIND_CHECK;
  logic [63:0] address_high = '0;
  logic [63:0] address_low = '0;
  logic is_ipv6 = 1'b0;
  logic [7:0] prefix_length = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  logic allowed;
  logic [1:0] status;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = CFG_FILTER_ENABLE;
  logic cfg_data = 1'b0;

  cidr_access_filter_core #(
    .ALLOW_DEPTH(ALLOW_DEPTH),
    .DENY_DEPTH (DENY_DEPTH)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .kind         (kind),
    .address_high (address_high),
    .address_low  (address_low),
    .is_ipv6      (is_ipv6),
    .prefix_length(prefix_length),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .allowed      (allowed),
    .status       (status),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  filter_req_t pending_reqs[$];
  verdict_t verdicts_due[$];
  rule_t offered_rules[$];
  int items_queued = 0;
  int verdicts_seen = 0;
  int mismatches = 0;
  int cycle_count = 0;
  bit calm_tail = 1'b0;

  rule_t allow_tbl[ALLOW_DEPTH];
  rule_t deny_tbl[DENY_DEPTH];
  int allow_used = 0;
  int deny_used = 0;
  bit filter_on = 1'b0;
  bit user_rules_on = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic bit rule_hits(rule_t r, addr_t a);
    logic [31:0] m4;
    logic [127:0] m6;
    if (r.family != a.family) return 1'b0;
    if (!a.family) begin
      m4 = (r.prefix == 0) ? 32'd0 : ~32'd0 << (32 - r.prefix);
      return ((r.low[31:0] ^ a.low[31:0]) & m4) == 32'd0;
    end
    m6 = (r.prefix == 0) ? 128'd0 : ~128'd0 << (128 - r.prefix);
    return (({r.high, r.low} ^ {a.high, a.low}) & m6) == 128'd0;
  endfunction

  function automatic bit is_loopback(addr_t a);
    if (a.family) return a.high == 64'd0 && a.low == 64'd1;
    return a.low[31:24] == V4_LOOPBACK_NET;
  endfunction

  function automatic verdict_t apply_request(filter_req_t rq);
    verdict_t v;
    addr_t a;
    rule_t r;
    logic [7:0] lim;
    bit hit_allow;
    bit hit_deny;
    v.allowed = 1'b0;
    v.status = STATUS_OK;
    a.family = rq.v6;
    a.high = rq.v6 ? rq.high : 64'd0;
    a.low = rq.v6 ? rq.low : {32'd0, rq.low[31:0]};
    lim = rq.v6 ? V6_MAX_PREFIX : V4_MAX_PREFIX;
    r.high = a.high;
    r.low = a.low;
    r.prefix = rq.plen;
    r.family = a.family;
    case (rq.kind)
      KIND_CHECK: begin
        v.allowed = 1'b1;
        if (filter_on && !is_loopback(a)) begin
          hit_allow = 1'b0;
          hit_deny = 1'b0;
          for (int i = 0; i < allow_used; i++)
            if (rule_hits(allow_tbl[i], a)) hit_allow = 1'b1;
          for (int i = 0; i < deny_used; i++)
            if (rule_hits(deny_tbl[i], a)) hit_deny = 1'b1;
          if (allow_used > 0 && !hit_allow && !user_rules_on) v.allowed = 1'b0;
          else if (deny_used > 0 && hit_deny) v.allowed = 1'b0;
        end
      end
      KIND_CLEAR: begin
        allow_used = 0;
        deny_used = 0;
      end
      default: begin
        if (rq.plen > lim) begin
          v.status = STATUS_TOO_LONG;
        end else if (rq.kind == KIND_ADD_ALLOW) begin
          if (allow_used >= ALLOW_DEPTH) v.status = STATUS_FULL;
          else begin
            allow_tbl[allow_used] = r;
            allow_used++;
          end
        end else begin
          if (deny_used >= DENY_DEPTH) v.status = STATUS_FULL;
          else begin
            deny_tbl[deny_used] = r;
            deny_used++;
          end
        end
      end
    endcase
    return v;
  endfunction

  function automatic void enqueue(kind_t k, logic [63:0] ah, logic [63:0] al, logic v6,
                                  logic [7:0] pl);
    filter_req_t rq;
    rule_t r;
    rq.kind = k;
    rq.high = ah;
    rq.low = al;
    rq.v6 = v6;
    rq.plen = pl;
    pending_reqs.push_back(rq);
    items_queued++;
    if ((k == KIND_ADD_ALLOW || k == KIND_ADD_DENY) && pl <= (v6 ? V6_MAX_PREFIX : V4_MAX_PREFIX))
    begin
      r.high = ah;
      r.low = al;
      r.prefix = pl;
      r.family = v6;
      offered_rules.push_back(r);
    end
  endfunction

  function automatic logic [7:0] pick_prefix(logic v6);
    int pick;
    int top;
    pick = $urandom_range(0, 19);
    top = v6 ? 128 : 32;
    if (pick == 0) return 8'($urandom_range(top + 1, 255));
    if (pick == 1) return 8'd0;
    if (pick == 2) return 8'(top);
    return 8'($urandom_range(0, top));
  endfunction

  function automatic void enqueue_probe(rule_t r);
    logic [127:0] keep;
    logic [127:0] full;
    logic [31:0] keep4;
    logic [31:0] low4;
    logic v6;
    int p;
    p = r.prefix;
    v6 = r.family;
    if (v6) begin
      keep = (p == 0) ? 128'd0 : ~128'd0 << (128 - p);
      full = ({r.high, r.low} & keep) | ({rand64(), rand64()} & ~keep);
      if (p > 0 && $urandom_range(0, 2) == 0) full[128 - $urandom_range(1, p)] ^= 1'b1;
    end else begin
      keep4 = (p == 0) ? 32'd0 : ~32'd0 << (32 - p);
      low4 = (r.low[31:0] & keep4) | ($urandom & ~keep4);
      if (p > 0 && $urandom_range(0, 2) == 0) low4[32 - $urandom_range(1, p)] ^= 1'b1;
      full = {rand64(), $urandom, low4};
    end
    if ($urandom_range(0, 9) == 0) v6 = ~v6;
    enqueue(KIND_CHECK, full[127:64], full[63:0], v6, 8'($urandom));
  endfunction

  function automatic void enqueue_random_check();
    logic v6;
    logic [63:0] ah;
    logic [63:0] al;
    v6 = $urandom_range(0, 1);
    ah = rand64();
    al = rand64();
    case ($urandom_range(0, 9))
      0: begin
        if (v6) begin
          ah = 64'd0;
          al = 64'd1;
        end else al[31:24] = V4_LOOPBACK_NET;
      end
      1: begin
        ah = 64'd0;
        al = 64'($urandom_range(0, 3));
      end
      default: ;
    endcase
    enqueue(KIND_CHECK, ah, al, v6, 8'($urandom));
  endfunction

  function automatic void queue_phase(int n_items);
    int made;
    int n_add;
    int n_chk;
    logic v6;
    made = 0;
    while (made < n_items) begin
      if ($urandom_range(0, 2) == 0) begin
        enqueue(KIND_CLEAR, rand64(), rand64(), 1'($urandom), 8'($urandom));
        offered_rules.delete();
        made++;
      end
      n_add = $urandom_range(0, 20);
      for (int i = 0; i < n_add; i++) begin
        v6 = $urandom_range(0, 1);
        enqueue($urandom_range(0, 1) ? KIND_ADD_ALLOW : KIND_ADD_DENY, rand64(), rand64(), v6,
                pick_prefix(v6));
        made++;
      end
      n_chk = $urandom_range(4, 24);
      for (int i = 0; i < n_chk; i++) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: begin
            if (offered_rules.size() > 0)
              enqueue_probe(offered_rules[$urandom_range(0, offered_rules.size() - 1)]);
            else enqueue_random_check();
          end
          6, 7: enqueue_random_check();
          default: enqueue(kind_t'($urandom_range(0, 3)), rand64(), rand64(), 1'($urandom),
                           8'($urandom));
        endcase
        made++;
      end
    end
  endfunction

  task automatic cfg_write(logic [CFG_INDEX_W-1:0] idx, logic value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_FILTER_ENABLE: filter_on = value;
      CFG_USER_RULES: user_rules_on = value;
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    do @(posedge clk); while (verdicts_seen != items_queued);
  endtask

  task automatic note_mismatch(string what, logic [1:0] got, logic [1:0] want);
    mismatches++;
    $display("mismatch on result %0d: %s got %0d expected %0d", verdicts_seen, what, got, want);
  endtask

  // Sender: an offered transfer is held until it is taken, then the next one
  // or a random gap follows.
  int gap_left = 0;
  filter_req_t on_offer;

  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      gap_left = 0;
    end else if (!req_valid || !req_stall) begin
      if (req_valid) verdicts_due.push_back(apply_request(on_offer));
      if (gap_left > 0) begin
        gap_left--;
        req_valid <= 1'b0;
      end else if (!calm_tail && $urandom_range(0, 5) == 0) begin
        gap_left = $urandom_range(1, 8) - 1;
        req_valid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        on_offer = pending_reqs.pop_front();
        kind <= on_offer.kind;
        address_high <= on_offer.high;
        address_low <= on_offer.low;
        is_ipv6 <= on_offer.v6;
        prefix_length <= on_offer.plen;
        req_valid <= 1'b1;
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // Receiver stall: short random bursts, and one long hold-off.
  int stall_left = 0;
  int hold_left = 0;
  int rsp_taken = 0;
  bit hold_done = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) rsp_taken++;
      if (!hold_done && rsp_taken >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        rsp_stall <= 1'b1;
      end else if (!calm_tail && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 8) - 1;
        rsp_stall <= 1'b1;
      end else begin
        rsp_stall <= 1'b0;
      end
    end
  end

  verdict_t want;

  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      if (verdicts_due.size() == 0) begin
        note_mismatch("result with nothing outstanding, status", status, STATUS_OK);
      end else begin
        want = verdicts_due.pop_front();
        if (allowed !== want.allowed) note_mismatch("allowed", allowed, want.allowed);
        if (status !== want.status) note_mismatch("status", status, want.status);
        verdicts_seen++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("cidr_access_filter_core verification failed");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    cfg_write(CFG_FILTER_ENABLE, 1'b1);
    cfg_write(CFG_USER_RULES, 1'b0);
    cfg_valid <= 1'b0;

    enqueue(KIND_CHECK, 64'd0, 64'h0000_0000_0A01_0203, 1'b0, 8'd0);
    enqueue(KIND_ADD_ALLOW, ~64'd0, 64'hFFFF_FFFF_0A00_0000, 1'b0, 8'd8);
    enqueue(KIND_CHECK, ~64'd0, 64'hFFFF_FFFF_0A01_0203, 1'b0, 8'hFF);
    enqueue(KIND_CHECK, 64'd0, 64'h0000_0000_0B00_0001, 1'b0, 8'd0);
    enqueue(KIND_CHECK, ~64'd0, 64'hFFFF_FFFF_7F00_0001, 1'b0, 8'd0);
    enqueue(KIND_CHECK, 64'd0, 64'd1, 1'b1, 8'd0);
    enqueue(KIND_CHECK, 64'd0, 64'd1, 1'b0, 8'd0);
    enqueue(KIND_ADD_ALLOW, 64'd0, 64'h0A00_0000, 1'b0, 8'd33);
    enqueue(KIND_ADD_DENY, rand64(), rand64(), 1'b1, 8'd129);
    enqueue(KIND_ADD_DENY, rand64(), rand64(), 1'b0, 8'hFF);
    enqueue(KIND_ADD_ALLOW, ~64'd0, ~64'd0, 1'b1, 8'd128);
    enqueue(KIND_CHECK, ~64'd0, ~64'd0, 1'b1, 8'd0);
    enqueue(KIND_CHECK, ~64'd0, ~64'd1, 1'b1, 8'd0);
    enqueue(KIND_ADD_DENY, 64'd0, 64'h0A01_0000, 1'b0, 8'd16);
    enqueue(KIND_CHECK, 64'd0, 64'h0A01_0505, 1'b0, 8'd0);
    enqueue(KIND_CHECK, 64'd0, 64'h0A02_0505, 1'b0, 8'd0);
    enqueue(KIND_ADD_ALLOW, rand64(), rand64(), 1'b1, 8'd0);
    enqueue(KIND_CHECK, rand64(), rand64(), 1'b1, 8'd0);
    enqueue(KIND_ADD_DENY, 64'd0, 64'hFFFF_FFFF, 1'b0, 8'd32);
    enqueue(KIND_ADD_ALLOW, rand64(), rand64(), 1'b0, 8'd0);
    enqueue(KIND_CHECK, 64'd0, 64'hFFFF_FFFF, 1'b0, 8'd0);
    enqueue(KIND_CHECK, 64'd0, 64'hFFFF_FFFE, 1'b0, 8'd0);
    enqueue(KIND_CLEAR, 64'd0, 64'd0, 1'b0, 8'd0);
    enqueue(KIND_CHECK, 64'd0, 64'h0B00_0001, 1'b0, 8'd0);
    offered_rules.delete();
    wait_idle();

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin
          cfg_write(CFG_FILTER_ENABLE, 1'b1);
          cfg_write(CFG_USER_RULES, 1'b0);
        end
        1: begin
          cfg_write(CFG_USER_RULES, 1'b1);
        end
        2: begin
          cfg_write(CFG_FILTER_ENABLE, 1'b0);
          cfg_write(CFG_USER_RULES, 1'b0);
        end
        3: begin
          cfg_write(CFG_USER_RULES, 1'b1);
          cfg_write(CFG_UNUSED, 1'b1);
        end
        PHASES - 1: begin
          calm_tail = 1'b1;
          cfg_write(CFG_FILTER_ENABLE, 1'b1);
          cfg_write(CFG_USER_RULES, 1'b0);
        end
        default: begin
          cfg_write(CFG_FILTER_ENABLE, ($urandom_range(0, 3) != 0));
          cfg_write(CFG_USER_RULES, 1'($urandom));
        end
      endcase
      cfg_valid <= 1'b0;
      queue_phase(PHASE_ITEMS);
      wait_idle();
    end

    repeat (ALLOW_DEPTH + DENY_DEPTH + 8) @(posedge clk);
    if (mismatches == 0 && verdicts_due.size() == 0)
      $display("cidr_access_filter_core verification clean");
    else
      $display("cidr_access_filter_core verification failed");
    $finish;
  end

endmodule
